// ===== rtl/cdpc_pkg.sv =====
// Package for the cone dominance pair counter.
// Holds field widths, register indexes, reset values and the token types.
// No dependencies.
package cdpc_pkg;

    localparam int COORD_W        = 31;
    localparam int PROD_W         = 2 * COORD_W;
    localparam int KEY_W          = 64;
    localparam int COUNT_W        = 19;
    localparam int CFG_IDX_W      = 2;
    localparam int DEF_MAX_POINTS = 1024;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] REG_LEFT_X  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_Y  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_X = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_Y = 2'd3;

    localparam logic signed [COORD_W-1:0] RST_LEFT_X  = 31'sd1;
    localparam logic signed [COORD_W-1:0] RST_LEFT_Y  = 31'sd0;
    localparam logic signed [COORD_W-1:0] RST_RIGHT_X = 31'sd0;
    localparam logic signed [COORD_W-1:0] RST_RIGHT_Y = -31'sd1;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [KEY_W-1:0]   key_t;

    typedef struct packed {
        key_t   lkey;
        key_t   rkey;
        coord_t x;
    } point_t;

    // valid: token present; store: point kept and compared;
    // last: closes the set; ovf: set had dropped points (last token only)
    typedef struct packed {
        logic valid;
        logic store;
        logic last;
        logic ovf;
    } ctl_t;

endpackage

// ===== rtl/cdpc_in_if.sv =====
// Point request channel of the cone dominance pair counter.
// Depends on cdpc_pkg for field widths.
interface cdpc_in_if;
    logic                               valid;
    logic                               ready;
    logic signed [cdpc_pkg::COORD_W-1:0] point_x;
    logic signed [cdpc_pkg::COORD_W-1:0] point_y;
    logic                               last_point;

    modport source (output valid, output point_x, output point_y, output last_point,
                    input ready);
    modport sink   (input valid, input point_x, input point_y, input last_point,
                    output ready);
endinterface

// ===== rtl/cdpc_out_if.sv =====
// Result request channel of the cone dominance pair counter.
// Depends on cdpc_pkg for field widths.
interface cdpc_out_if;
    logic                         valid;
    logic                         ready;
    logic [cdpc_pkg::COUNT_W-1:0] pair_count;
    logic                         overflow;

    modport source (output valid, output pair_count, output overflow, input ready);
    modport sink   (input valid, input pair_count, input overflow, output ready);
endinterface

// ===== rtl/cdpc_proj.sv =====
// Front end: coefficient registers, fill count, and the two-stage key projection.
// Depends on cdpc_pkg and cdpc_in_if.
module cdpc_proj #(
    parameter int MAX_POINTS = cdpc_pkg::DEF_MAX_POINTS,
    parameter int IW         = $clog2(MAX_POINTS)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            adv,
    input  logic                            cfg_we,
    input  logic [cdpc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cdpc_pkg::COORD_W-1:0]    cfg_data,
    cdpc_in_if.sink                         point_in,
    output cdpc_pkg::ctl_t                  ctl_out,
    output cdpc_pkg::point_t                pt_out,
    output logic [IW-1:0]                   idx_out
);
    import cdpc_pkg::*;

    localparam int HW = $clog2(MAX_POINTS + 1);

    coord_t lcx_reg, lcy_reg, rcx_reg, rcy_reg;

    logic [HW-1:0] held_reg, held_next;
    logic          drop_reg, drop_next;

    ctl_t                      s1_ctl_reg, s2_ctl_reg;
    logic [IW-1:0]             s1_idx_reg, s2_idx_reg;
    coord_t                    s1_x_reg;
    logic signed [PROD_W-1:0]  p_lx_reg, p_ly_reg, p_rx_reg, p_ry_reg;
    point_t                    s2_pt_reg;

    logic accept;
    logic full;
    ctl_t in_ctl;

    assign point_in.ready = adv;
    assign accept         = point_in.valid & adv;
    assign full           = (held_reg == HW'(MAX_POINTS));

    always_comb
    begin
        in_ctl.valid = accept;
        in_ctl.store = ~full;
        in_ctl.last  = point_in.last_point;
        in_ctl.ovf   = drop_reg | full;
    end

    always_comb
    begin
        held_next = held_reg;
        drop_next = drop_reg;
        if (accept)
        begin
            if (point_in.last_point)
            begin
                held_next = '0;
                drop_next = 1'b0;
            end
            else if (full)
            begin
                drop_next = 1'b1;
            end
            else
            begin
                held_next = held_reg + HW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lcx_reg <= RST_LEFT_X;
            lcy_reg <= RST_LEFT_Y;
            rcx_reg <= RST_RIGHT_X;
            rcy_reg <= RST_RIGHT_Y;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LEFT_X:  lcx_reg <= cfg_data;
                REG_LEFT_Y:  lcy_reg <= cfg_data;
                REG_RIGHT_X: rcx_reg <= cfg_data;
                REG_RIGHT_Y: rcy_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg   <= '0;
            drop_reg   <= 1'b0;
            s1_ctl_reg <= '0;
            s2_ctl_reg <= '0;
        end
        else
        begin
            held_reg <= held_next;
            drop_reg <= drop_next;
            if (adv)
            begin
                s1_ctl_reg <= in_ctl;
                s2_ctl_reg <= s1_ctl_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_idx_reg <= held_reg[IW-1:0];
            s1_x_reg   <= point_in.point_x;
            p_lx_reg   <= PROD_W'(point_in.point_x) * PROD_W'(lcx_reg);
            p_ly_reg   <= PROD_W'(point_in.point_y) * PROD_W'(lcy_reg);
            p_rx_reg   <= PROD_W'(point_in.point_x) * PROD_W'(rcx_reg);
            p_ry_reg   <= PROD_W'(point_in.point_y) * PROD_W'(rcy_reg);

            s2_idx_reg     <= s1_idx_reg;
            s2_pt_reg.x    <= s1_x_reg;
            s2_pt_reg.lkey <= {{(KEY_W-PROD_W){p_lx_reg[PROD_W-1]}}, p_lx_reg}
                            - {{(KEY_W-PROD_W){p_ly_reg[PROD_W-1]}}, p_ly_reg};
            s2_pt_reg.rkey <= {{(KEY_W-PROD_W){p_rx_reg[PROD_W-1]}}, p_rx_reg}
                            - {{(KEY_W-PROD_W){p_ry_reg[PROD_W-1]}}, p_ry_reg};
        end
    end

    assign ctl_out = s2_ctl_reg;
    assign pt_out  = s2_pt_reg;
    assign idx_out = s2_idx_reg;

endmodule

// ===== rtl/cdpc_cell.sv =====
// One cell of the comparison chain: holds one stored point, compares each passing
// stored token of a higher index against it, and stores the token that carries its index.
// Depends on cdpc_pkg.
module cdpc_cell #(
    parameter int CELL_IDX = 0,
    parameter int IW       = 10,
    parameter int CW       = 10
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  cdpc_pkg::ctl_t   ctl_in,
    input  cdpc_pkg::point_t pt_in,
    input  logic [IW-1:0]    idx_in,
    input  logic [CW-1:0]    cnt_in,
    output cdpc_pkg::ctl_t   ctl_out,
    output cdpc_pkg::point_t pt_out,
    output logic [IW-1:0]    idx_out,
    output logic [CW-1:0]    cnt_out
);
    import cdpc_pkg::*;

    point_t        sto_reg;
    ctl_t          ctl_reg;
    point_t        pt_reg;
    logic [IW-1:0] idx_reg;
    logic [CW-1:0] cnt_reg, cnt_next;

    key_t   sl, sr, nl, nr;
    coord_t sx, nx;
    logic   cmp_en, wr_en;
    logic   l_lt, l_eq, r_lt, r_eq, x_eq, x_gt, x_lt;
    logic   l_first, r_first, l_tie, r_tie, hit;

    assign cmp_en = ctl_in.valid & ctl_in.store & (idx_in > IW'(CELL_IDX));
    assign wr_en  = adv & ctl_in.valid & ctl_in.store & (idx_in == IW'(CELL_IDX));

    always_comb
    begin
        sl = $signed(sto_reg.lkey);
        sr = $signed(sto_reg.rkey);
        sx = $signed(sto_reg.x);
        nl = $signed(pt_in.lkey);
        nr = $signed(pt_in.rkey);
        nx = $signed(pt_in.x);

        l_lt = sl < nl;
        l_eq = sl == nl;
        r_lt = sr < nr;
        r_eq = sr == nr;
        x_eq = sx == nx;
        x_gt = sx > nx;
        x_lt = sx < nx;

        // stored point first: l ties go to larger x, r ties to smaller x
        l_first = l_lt | (l_eq & x_gt);
        r_first = r_lt | (r_eq & x_lt);
        l_tie   = l_eq & x_eq;
        r_tie   = r_eq & x_eq;
        hit     = cmp_en & ~l_tie & ~r_tie & (l_first ^ r_first);

        cnt_next = cnt_in + CW'(hit);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (adv)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pt_reg  <= pt_in;
            idx_reg <= idx_in;
            cnt_reg <= cnt_next;
        end
        if (wr_en)
        begin
            sto_reg <= pt_in;
        end
    end

    assign ctl_out = ctl_reg;
    assign pt_out  = pt_reg;
    assign idx_out = idx_reg;
    assign cnt_out = cnt_reg;

endmodule

// ===== rtl/cone_dominance_pair_counter.sv =====
// Top level of the cone dominance pair counter: projection front end, chain
// of comparison cells, and the result accumulator.
// Depends on cdpc_pkg, cdpc_in_if, cdpc_out_if, cdpc_proj, cdpc_cell.
//
//  channel     role   carries
//  point_in    sink   point_x, point_y, last_point
//  result_out  source pair_count, overflow (one request per point set)
//  cfg_*       write  cfg_index selects coefficient, cfg_data value
//
// One point is taken every cycle unless the chain holds. A point walks one cell per cycle
// through MAX_POINTS cells while the chain advances; the set result is registered at the end.
// The whole chain holds only while a finished result waits on result_out and
// the next last point reaches the end. Reset needs no clearing pass.
module cone_dominance_pair_counter #(
    parameter int MAX_POINTS = cdpc_pkg::DEF_MAX_POINTS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [cdpc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cdpc_pkg::COORD_W-1:0]   cfg_data,
    cdpc_in_if.sink                        point_in,
    cdpc_out_if.source                     result_out
);
    import cdpc_pkg::*;

    localparam int IW = $clog2(MAX_POINTS);
    localparam int CW = IW;

    ctl_t          ch_ctl [MAX_POINTS+1];
    point_t        ch_pt  [MAX_POINTS+1];
    logic [IW-1:0] ch_idx [MAX_POINTS+1];
    logic [CW-1:0] ch_cnt [MAX_POINTS+1];

    logic               adv;
    logic [COUNT_W-1:0] run_reg, run_next;
    logic               out_valid_reg, out_valid_next;
    logic [COUNT_W-1:0] out_count_reg, out_count_next;
    logic               out_ovf_reg, out_ovf_next;
    logic [COUNT_W:0]   sum;
    logic [COUNT_W-1:0] sum_sat;
    ctl_t               tail;

    assign tail = ch_ctl[MAX_POINTS];
    assign adv  = ~(tail.valid & tail.last & out_valid_reg & ~result_out.ready);

    cdpc_proj #(
        .MAX_POINTS (MAX_POINTS),
        .IW         (IW)
    ) u_proj (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .point_in  (point_in),
        .ctl_out   (ch_ctl[0]),
        .pt_out    (ch_pt[0]),
        .idx_out   (ch_idx[0])
    );

    assign ch_cnt[0] = '0;

    for (genvar i = 0; i < MAX_POINTS; i++)
    begin : g_cell
        cdpc_cell #(
            .CELL_IDX (i),
            .IW       (IW),
            .CW       (CW)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .ctl_in  (ch_ctl[i]),
            .pt_in   (ch_pt[i]),
            .idx_in  (ch_idx[i]),
            .cnt_in  (ch_cnt[i]),
            .ctl_out (ch_ctl[i+1]),
            .pt_out  (ch_pt[i+1]),
            .idx_out (ch_idx[i+1]),
            .cnt_out (ch_cnt[i+1])
        );
    end

    always_comb
    begin
        sum     = {1'b0, run_reg} + (COUNT_W+1)'(ch_cnt[MAX_POINTS]);
        sum_sat = sum[COUNT_W] ? COUNT_MAX : sum[COUNT_W-1:0];

        run_next       = run_reg;
        out_valid_next = out_valid_reg & ~result_out.ready;
        out_count_next = out_count_reg;
        out_ovf_next   = out_ovf_reg;

        if (adv & tail.valid)
        begin
            if (tail.last)
            begin
                run_next       = '0;
                out_valid_next = 1'b1;
                out_count_next = sum_sat;
                out_ovf_next   = tail.ovf;
            end
            else
            begin
                run_next = sum_sat;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            run_reg       <= run_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_count_reg <= out_count_next;
        out_ovf_reg   <= out_ovf_next;
    end

    assign result_out.valid      = out_valid_reg;
    assign result_out.pair_count = out_count_reg;
    assign result_out.overflow   = out_ovf_reg;

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for cone_dominance_pair_counter: point sets with a
// scoreboard of predicted pair counts. Depends on cdpc_pkg, cdpc_in_if and
// cdpc_out_if, and the RTL of the block.
module testbench;
    import cdpc_pkg::*;

    localparam int     SETTLE_CYCLES = DEF_MAX_POINTS + 3 + 32;
    localparam int     STALL_LIMIT   = 20000;
    localparam coord_t COORD_MIN     = {1'b1, {(COORD_W-1){1'b0}}};
    localparam coord_t COORD_MAX     = {1'b0, {(COORD_W-1){1'b1}}};

    typedef enum int {SPREAD_NARROW, SPREAD_FULL, SPREAD_EDGES, SPREAD_MIXED} spread_e;

    typedef struct packed {
        logic [COUNT_W-1:0] pair_count;
        logic               overflow;
    } tally_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_LEFT_X;
    coord_t               cfg_data = '0;

    cdpc_in_if  point_bus ();
    cdpc_out_if result_bus ();

    cone_dominance_pair_counter dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .point_in   (point_bus),
        .result_out (result_bus)
    );

    // predictor state
    coord_t left_x  = RST_LEFT_X;
    coord_t left_y  = RST_LEFT_Y;
    coord_t right_x = RST_RIGHT_X;
    coord_t right_y = RST_RIGHT_Y;
    longint held_lkey [DEF_MAX_POINTS];
    longint held_rkey [DEF_MAX_POINTS];
    coord_t held_x    [DEF_MAX_POINTS];
    int     held_count = 0;
    int     pair_total = 0;
    bit     dropped = 1'b0;

    tally_t expected_tallies [$];
    tally_t due;
    int     mismatches = 0;
    int     results_checked = 0;
    int     overflow_sets = 0;
    int     points_sent = 0;
    int     coef_writes = 0;
    int     quiet_cycles = 0;
    bit     gaps_on = 1'b1;

    always #6 clk = ~clk;

    initial
    begin
        point_bus.valid      = 1'b0;
        point_bus.point_x    = '0;
        point_bus.point_y    = '0;
        point_bus.last_point = 1'b0;
        result_bus.ready     = 1'b0;
    end

    function automatic coord_t pick_coord(spread_e spread);
        spread_e sel;
        sel = (spread == SPREAD_MIXED) ? spread_e'($urandom_range(0, 2)) : spread;
        case (sel)
            SPREAD_NARROW: return coord_t'(int'($urandom_range(0, 8)) - 4);
            SPREAD_FULL:   return coord_t'($urandom());
            default:
                case ($urandom_range(0, 4))
                    0:       return COORD_MIN;
                    1:       return COORD_MAX;
                    2:       return coord_t'(0);
                    3:       return coord_t'(-1);
                    default: return coord_t'(1);
                endcase
        endcase
    endfunction

    task automatic absorb_point(coord_t x, coord_t y, bit last);
        longint lk;
        longint rk;
        int     a;
        int     b;
        if (held_count < DEF_MAX_POINTS)
        begin
            lk = longint'(x) * longint'(left_x) - longint'(y) * longint'(left_y);
            rk = longint'(x) * longint'(right_x) - longint'(y) * longint'(right_y);
            for (int i = 0; i < held_count; i++)
            begin
                if (held_lkey[i] != lk)
                    a = (held_lkey[i] < lk) ? -1 : 1;
                else if (held_x[i] != x)
                    a = (held_x[i] > x) ? -1 : 1;
                else
                    a = 0;
                if (held_rkey[i] != rk)
                    b = (held_rkey[i] < rk) ? -1 : 1;
                else if (held_x[i] != x)
                    b = (held_x[i] < x) ? -1 : 1;
                else
                    b = 0;
                if (a != 0 && b != 0 && a != b && pair_total < COUNT_MAX)
                    pair_total++;
            end
            held_lkey[held_count] = lk;
            held_rkey[held_count] = rk;
            held_x[held_count]    = x;
            held_count++;
        end
        else
            dropped = 1'b1;
        points_sent++;
        if (last)
        begin
            expected_tallies.push_back('{pair_count: COUNT_W'(pair_total), overflow: dropped});
            held_count = 0;
            pair_total = 0;
            dropped    = 1'b0;
        end
    endtask

    task automatic send_point(coord_t x, coord_t y, bit last);
        int gap;
        if (gaps_on && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 17);
            @(negedge clk);
            point_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        @(negedge clk);
        point_bus.valid      <= 1'b1;
        point_bus.point_x    <= x;
        point_bus.point_y    <= y;
        point_bus.last_point <= last;
        do
            @(posedge clk);
        while (point_bus.ready !== 1'b1);
        absorb_point(x, y, last);
    endtask

    task automatic send_set(int n, spread_e spread);
        for (int k = 0; k < n; k++)
            send_point(pick_coord(spread), pick_coord(spread), k == n - 1);
    endtask

    task automatic write_coef(logic [CFG_IDX_W-1:0] idx, coord_t value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_LEFT_X:  left_x  = value;
            REG_LEFT_Y:  left_y  = value;
            REG_RIGHT_X: right_x = value;
            REG_RIGHT_Y: right_y = value;
            default: ;
        endcase
        coef_writes++;
    endtask

    task automatic write_all_coefs(coord_t lx, coord_t ly, coord_t rx, coord_t ry);
        write_coef(REG_LEFT_X, lx);
        write_coef(REG_LEFT_Y, ly);
        write_coef(REG_RIGHT_X, rx);
        write_coef(REG_RIGHT_Y, ry);
    endtask

    // sender holds off until every pending result is back, then lets the chain empty
    task automatic drain_and_settle();
        @(negedge clk);
        point_bus.valid <= 1'b0;
        while (expected_tallies.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic test_default_projection();
        send_point(COORD_MAX, COORD_MIN, 1'b1);
        repeat (2) send_point(coord_t'(3), coord_t'(7), 1'b0);
        send_point(coord_t'(3), coord_t'(7), 1'b1);
        send_point(COORD_MIN, COORD_MIN, 1'b0);
        send_point(COORD_MAX, COORD_MAX, 1'b0);
        send_point(COORD_MIN, COORD_MAX, 1'b0);
        send_point(COORD_MAX, COORD_MIN, 1'b0);
        send_point(coord_t'(0), coord_t'(0), 1'b0);
        send_point(coord_t'(-1), coord_t'(1), 1'b1);
        // same x: tied in the left order
        send_point(coord_t'(2), coord_t'(5), 1'b0);
        send_point(coord_t'(2), coord_t'(-5), 1'b0);
        send_point(coord_t'(2), coord_t'(0), 1'b1);
        // same y: right order falls back to x
        send_point(coord_t'(1), coord_t'(4), 1'b0);
        send_point(coord_t'(2), coord_t'(4), 1'b0);
        send_point(coord_t'(-3), coord_t'(4), 1'b1);
        drain_and_settle();
    endtask

    task automatic test_coefficient_extremes();
        write_all_coefs(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN);
        send_point(COORD_MAX, COORD_MAX, 1'b0);
        send_point(COORD_MIN, COORD_MIN, 1'b0);
        send_point(COORD_MAX, COORD_MIN, 1'b0);
        send_point(COORD_MIN, COORD_MAX, 1'b0);
        send_point(coord_t'(1), coord_t'(-1), 1'b1);
        drain_and_settle();
        // left key constant: left order decided by x alone
        write_all_coefs(coord_t'(0), coord_t'(0), coord_t'(-1), coord_t'(1));
        send_point(coord_t'(4), coord_t'(0), 1'b0);
        send_point(coord_t'(-4), coord_t'(0), 1'b0);
        send_point(coord_t'(4), coord_t'(0), 1'b0);
        send_point(coord_t'(0), coord_t'(9), 1'b1);
        drain_and_settle();
    endtask

    task automatic test_store_full();
        write_all_coefs(RST_LEFT_X, RST_LEFT_Y, RST_RIGHT_X, RST_RIGHT_Y);
        // x rising, y falling: every stored pair disagrees
        for (int i = 0; i < DEF_MAX_POINTS; i++)
            send_point(coord_t'(i * 5 + int'($urandom_range(0, 4))),
                       coord_t'(-(i * 5) - int'($urandom_range(0, 4))), 1'b0);
        repeat (3) send_point(pick_coord(SPREAD_FULL), pick_coord(SPREAD_FULL), 1'b0);
        send_point(pick_coord(SPREAD_FULL), pick_coord(SPREAD_FULL), 1'b1);
        send_set(3, SPREAD_MIXED);
        drain_and_settle();
    endtask

    task automatic test_random_settings();
        spread_e coef_spread;
        int      budget;
        int      n;
        int      roll;
        for (int s = 0; s < 6; s++)
        begin
            gaps_on = (s != 2);
            coef_spread = (s == 0) ? SPREAD_NARROW : spread_e'($urandom_range(0, 3));
            write_all_coefs(pick_coord(coef_spread), pick_coord(coef_spread),
                            pick_coord(coef_spread), pick_coord(coef_spread));
            budget = 130;
            while (budget > 0)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 15)
                    n = 1;
                else if (roll < 85)
                    n = $urandom_range(2, 24);
                else
                    n = $urandom_range(25, 64);
                if (n > budget)
                    n = budget;
                send_set(n, spread_e'($urandom_range(0, 3)));
                budget -= n;
            end
            drain_and_settle();
        end
        gaps_on = 1'b1;
    endtask

    task automatic test_back_to_back();
        int budget;
        int n;
        gaps_on = 1'b0;
        write_all_coefs(pick_coord(SPREAD_FULL), pick_coord(SPREAD_FULL),
                        pick_coord(SPREAD_NARROW), pick_coord(SPREAD_NARROW));
        budget = 100;
        while (budget > 0)
        begin
            n = $urandom_range(1, 12);
            if (n > budget)
                n = budget;
            send_set(n, SPREAD_MIXED);
            budget -= n;
        end
        drain_and_settle();
    endtask

    initial
    begin
        forever
        begin
            @(negedge clk);
            if (gaps_on && $urandom_range(0, 5) == 0)
            begin
                result_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 17) - 1) @(negedge clk);
            end
            else
            begin
                result_bus.ready <= 1'b1;
                repeat ($urandom_range(1, 30) - 1) @(negedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (result_bus.valid === 1'b1 && result_bus.ready === 1'b1)
        begin
            if (expected_tallies.size() == 0)
            begin
                $display("%0t: result with none pending: expected none, actual count %0d ovf %0b",
                         $time, result_bus.pair_count, result_bus.overflow);
                mismatches++;
            end
            else
            begin
                due = expected_tallies.pop_front();
                if (result_bus.pair_count !== due.pair_count)
                begin
                    $display("%0t: pair_count: expected %0d, actual %0d",
                             $time, due.pair_count, result_bus.pair_count);
                    mismatches++;
                end
                if (result_bus.overflow !== due.overflow)
                begin
                    $display("%0t: overflow: expected %0b, actual %0b",
                             $time, due.overflow, result_bus.overflow);
                    mismatches++;
                end
                if (due.overflow)
                    overflow_sets++;
                results_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((point_bus.valid === 1'b1 && point_bus.ready === 1'b1) ||
            (result_bus.valid === 1'b1 && result_bus.ready === 1'b1))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no request accepted for %0d cycles", $time, STALL_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_default_projection();
        test_coefficient_extremes();
        test_store_full();
        test_random_settings();
        test_back_to_back();
        $display("Sent %0d points, checked %0d set results (%0d with dropped points)",
                 points_sent, results_checked, overflow_sets);
        $display("Coefficient writes: %0d, covering reset, extreme and random projections",
                 coef_writes);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/cdpc_pkg.sv
rtl/cdpc_in_if.sv
rtl/cdpc_out_if.sv
rtl/cdpc_proj.sv
rtl/cdpc_cell.sv
rtl/cone_dominance_pair_counter.sv
tb/sv/testbench.sv
